>>> hdl/hts_pkg.sv
package hts_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_EVENTS_DEF = 64;
    localparam int RATE_BITS_DEF  = 32;

    // Fixed field widths of the stream words.
    localparam int FIELD_W    = 32;
    localparam int INDEX_W    = 6;
    localparam int TOTAL_W    = 38;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    // Kind of an accepted input word, decided by the front end.
    typedef enum logic [1:0] {
        K_LOAD      = 2'd0,
        K_LOAD_LAST = 2'd1,
        K_QUERY     = 2'd2
    } hts_kind_t;

    // Status code of a result word.
    typedef enum logic [1:0] {
        ST_BUILT    = 2'd0,
        ST_SAMPLE   = 2'd1,
        ST_NO_TREE  = 2'd2,
        ST_OVERFLOW = 2'd3
    } hts_status_t;

    // One classified input word as it sits in the queue.
    typedef struct packed {
        hts_kind_t            kind;
        logic [FIELD_W-1:0]   rate;
        logic [FIELD_W-1:0]   draw;
    } hts_item_t;

    // One result word.
    typedef struct packed {
        hts_status_t          status;
        logic [INDEX_W-1:0]   index;
        logic [TOTAL_W-1:0]   total;
    } hts_result_t;

    // Back-end sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_SORT_RI,
        S_SORT_SI,
        S_SORT_RJ,
        S_SORT_CJ,
        S_SORT_WR,
        S_PR_A,
        S_PR_B,
        S_PR_C,
        S_PR_W,
        S_MG_RD,
        S_MG_CMP,
        S_MG_WR,
        S_TH_INIT,
        S_TH_RD,
        S_TH_C,
        S_TH_W1,
        S_TH_W2,
        S_DONE,
        S_Q_M1,
        S_Q_M2,
        S_Q_WALK
    } hts_state_t;

endpackage

>>> hdl/hts_front.sv
module hts_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [hts_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // event_rate, uniform_draw
    input  logic                            s_axis_tlast,   // last_event
    input  logic                            s_axis_tuser,   // mode
    output logic                            item_valid,
    input  logic                            item_ready,
    output hts_pkg::hts_item_t              item
);
    import hts_pkg::*;

    hts_item_t   q_mem [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    logic        pop;
    hts_item_t   in_item;

    // Classify the incoming word.
    always_comb
    begin
        in_item.rate = s_axis_tdata[FIELD_W-1:0];
        in_item.draw = s_axis_tdata[IN_DATA_W-1:FIELD_W];
        priority if (s_axis_tuser)
        begin
            in_item.kind = K_QUERY;
        end
        else if (s_axis_tlast)
        begin
            in_item.kind = K_LOAD_LAST;
        end
        else
        begin
            in_item.kind = K_LOAD;
        end
    end

    // Two-entry queue toward the back end.
    assign s_axis_tready = (cnt_reg != 2'd2);
    assign item_valid    = (cnt_reg != 2'd0);
    assign item          = q_mem[rp_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = item_valid && item_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= in_item;
        end
    end

endmodule

>>> hdl/hts_back.sv
module hts_back #(
    parameter int MAX_EVENTS = hts_pkg::MAX_EVENTS_DEF,
    parameter int RATE_BITS  = hts_pkg::RATE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  hts_pkg::hts_item_t   item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output hts_pkg::hts_result_t res
);
    import hts_pkg::*;

    localparam int IDX_W  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_EVENTS + 1);
    localparam int RW     = (RATE_BITS < FIELD_W) ? RATE_BITS : FIELD_W;
    localparam int SUM_W0 = RW + IDX_W + 1;
    localparam int SUM_W  = (SUM_W0 > FIELD_W) ? SUM_W0 : FIELD_W + 1;
    localparam int HI_W   = SUM_W - FIELD_W;
    localparam int PHI_W  = FIELD_W + HI_W;
    localparam int PLO_W  = 2 * FIELD_W;

    // Storage.
    logic [RW-1:0]    rate_mem [MAX_EVENTS];
    logic [IDX_W-1:0] ord_mem  [MAX_EVENTS];
    logic [IDX_W-1:0] nl_mem   [MAX_EVENTS];
    logic [IDX_W-1:0] nr_mem   [MAX_EVENTS];
    logic             np_mem   [MAX_EVENTS];
    logic [SUM_W-1:0] nw_mem   [MAX_EVENTS];
    logic [SUM_W-1:0] thr_mem  [MAX_EVENTS];
    logic [SUM_W-1:0] acc_mem  [MAX_EVENTS];

    // Memory ports.
    logic             rate_we;
    logic [IDX_W-1:0] rate_wa, rate_ra;
    logic [RW-1:0]    rate_wd, rate_rd_reg;
    logic             ord_we;
    logic [IDX_W-1:0] ord_wa, ord_ra;
    logic [IDX_W-1:0] ord_wd, ord_rd_reg;
    logic             node_we;
    logic [IDX_W-1:0] node_wa, node_ra;
    logic [IDX_W-1:0] nl_wd, nr_wd, nl_rd_reg, nr_rd_reg;
    logic             np_wd, np_rd_reg;
    logic [SUM_W-1:0] nw_wd, nw_rd_reg;
    logic             thr_we;
    logic [IDX_W-1:0] thr_wa;
    logic [SUM_W-1:0] thr_wd, thr_rd_reg;
    logic             acc_we;
    logic [IDX_W-1:0] acc_wa;
    logic [SUM_W-1:0] acc_wd, acc_rd_reg;

    // Control state.
    hts_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             ready_reg, ready_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] rank_reg, rank_next;
    logic [CNT_W-1:0] lv_reg, lv_next;
    logic [CNT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0] nx_reg, nx_next;
    logic             fa_reg, fa_next;
    logic             fb_reg, fb_next;
    logic [MAX_EVENTS-1:0] act_reg, act_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [IDX_W-1:0] a_reg, a_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic [SUM_W-1:0] wa_reg, wa_next;
    logic [SUM_W-1:0] wb_reg, wb_next;
    logic [RW-1:0]    ra_reg, ra_next;
    logic [RW-1:0]    ri_reg, ri_next;
    logic [FIELD_W-1:0] u_reg, u_next;
    logic [PLO_W-1:0] plo_reg, plo_next;
    logic [PHI_W-1:0] phi_reg, phi_next;
    logic [SUM_W-1:0] x_reg, x_next;
    hts_result_t      out_reg, out_next;

    // Helpers.
    logic             out_free;
    logic [CNT_W-1:0] eff_cnt, n1, lv_new, root_new;
    logic [SUM_W-1:0] eff_sum;
    logic             odd;
    logic [IDX_W-1:0] pidx_a, pidx_b;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] i_idx;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (rate_we)
        begin
            rate_mem[rate_wa] <= rate_wd;
        end
        rate_rd_reg <= rate_mem[rate_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_wa] <= ord_wd;
        end
        ord_rd_reg <= ord_mem[ord_ra];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            nl_mem[node_wa] <= nl_wd;
            nr_mem[node_wa] <= nr_wd;
            np_mem[node_wa] <= np_wd;
            nw_mem[node_wa] <= nw_wd;
        end
        nl_rd_reg <= nl_mem[node_ra];
        nr_rd_reg <= nr_mem[node_ra];
        np_rd_reg <= np_mem[node_ra];
        nw_rd_reg <= nw_mem[node_ra];
    end

    always_ff @(posedge clk)
    begin
        if (thr_we)
        begin
            thr_mem[thr_wa] <= thr_wd;
        end
        thr_rd_reg <= thr_mem[node_ra];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_wa] <= acc_wd;
        end
        acc_rd_reg <= acc_mem[node_ra];
    end

    // Shared helper values.
    always_comb
    begin
        eff_cnt  = ready_reg ? '0 : cnt_reg;
        eff_sum  = ready_reg ? '0 : sum_reg;
        n1       = eff_cnt + CNT_W'(1);
        lv_new   = CNT_W'(({1'b0, n1} + (CNT_W + 1)'(1)) >> 1);
        root_new = CNT_W'({lv_new, 1'b0} - (CNT_W + 1)'(2));
        odd      = ({i_reg, 1'b1} >= {1'b0, cnt_reg});
        pidx_a   = IDX_W'({i_reg, 1'b0});
        pidx_b   = IDX_W'({i_reg, 1'b1});
        i_idx    = i_reg[IDX_W-1:0];
        sel      = (x_reg > thr_rd_reg) ? nl_rd_reg : nr_rd_reg;
    end

    // Sequencer: next state, memory controls and result word.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        ready_next     = ready_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rank_next      = rank_reg;
        lv_next        = lv_reg;
        root_next      = root_reg;
        nx_next        = nx_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        act_next       = act_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        ra_next        = ra_reg;
        ri_next        = ri_reg;
        u_next         = u_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        item_ready     = 1'b0;

        rate_we = 1'b0;
        rate_wa = eff_cnt[IDX_W-1:0];
        rate_wd = item.rate[RW-1:0];
        rate_ra = i_idx;
        ord_we  = 1'b0;
        ord_wa  = rank_reg[IDX_W-1:0];
        ord_wd  = i_idx;
        ord_ra  = pidx_a;
        node_we = 1'b0;
        node_wa = i_idx;
        nl_wd   = a_reg;
        nr_wd   = b_reg;
        np_wd   = 1'b1;
        nw_wd   = wa_reg;
        node_ra = i_idx;
        thr_we  = 1'b0;
        thr_wa  = i_idx;
        thr_wd  = '0;
        acc_we  = 1'b0;
        acc_wa  = root_reg[IDX_W-1:0];
        acc_wd  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = out_free;
                if (item_valid && out_free)
                begin
                    if (item.kind == K_QUERY)
                    begin
                        if (!ready_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next.status = ST_NO_TREE;
                            out_next.index  = '0;
                            out_next.total  = '0;
                        end
                        else
                        begin
                            u_next     = item.draw;
                            state_next = S_Q_M1;
                        end
                    end
                    else
                    begin
                        ready_next = 1'b0;
                        if (eff_cnt == CNT_W'(MAX_EVENTS))
                        begin
                            cnt_next = '0;
                            sum_next = '0;
                            out_valid_next = 1'b1;
                            out_next.status = ST_OVERFLOW;
                            out_next.index  = '0;
                            out_next.total  = '0;
                        end
                        else
                        begin
                            rate_we  = 1'b1;
                            cnt_next = n1;
                            sum_next = eff_sum + SUM_W'(item.rate[RW-1:0]);
                            if (item.kind == K_LOAD_LAST)
                            begin
                                i_next     = '0;
                                lv_next    = lv_new;
                                root_next  = root_new;
                                state_next = S_SORT_RI;
                            end
                        end
                    end
                end
            end

            // Stable rank sort: count the events that go before event i.
            S_SORT_RI:
            begin
                rate_ra    = i_idx;
                state_next = S_SORT_SI;
            end
            S_SORT_SI:
            begin
                ri_next    = rate_rd_reg;
                j_next     = '0;
                rank_next  = '0;
                state_next = S_SORT_RJ;
            end
            S_SORT_RJ:
            begin
                rate_ra    = j_reg[IDX_W-1:0];
                state_next = S_SORT_CJ;
            end
            S_SORT_CJ:
            begin
                if ((rate_rd_reg < ri_reg) || ((rate_rd_reg == ri_reg) && (j_reg < i_reg)))
                begin
                    rank_next = rank_reg + CNT_W'(1);
                end
                j_next = j_reg + CNT_W'(1);
                if (j_reg == cnt_reg - CNT_W'(1))
                begin
                    state_next = S_SORT_WR;
                end
                else
                begin
                    state_next = S_SORT_RJ;
                end
            end
            S_SORT_WR:
            begin
                ord_we = 1'b1;
                if (i_reg == cnt_reg - CNT_W'(1))
                begin
                    i_next     = '0;
                    state_next = S_PR_A;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_SORT_RI;
                end
            end

            // Pair sorted neighbors into leaf nodes.
            S_PR_A:
            begin
                ord_ra     = pidx_a;
                state_next = S_PR_B;
            end
            S_PR_B:
            begin
                a_next     = ord_rd_reg;
                ord_ra     = pidx_b;
                rate_ra    = ord_rd_reg;
                state_next = S_PR_C;
            end
            S_PR_C:
            begin
                ra_next    = rate_rd_reg;
                b_next     = odd ? a_reg : ord_rd_reg;
                rate_ra    = odd ? a_reg : ord_rd_reg;
                state_next = S_PR_W;
            end
            S_PR_W:
            begin
                node_we = 1'b1;
                node_wa = i_idx;
                np_wd   = 1'b1;
                nw_wd   = odd ? SUM_W'(ra_reg) : SUM_W'(ra_reg) + SUM_W'(rate_rd_reg);
                thr_we  = 1'b1;
                thr_wa  = i_idx;
                thr_wd  = odd ? '0 : SUM_W'(rate_rd_reg);
                act_next[i_idx] = 1'b1;
                if (i_reg == lv_reg - CNT_W'(1))
                begin
                    nx_next = lv_reg;
                    if (lv_reg == CNT_W'(1))
                    begin
                        state_next = S_TH_INIT;
                    end
                    else
                    begin
                        i_next     = '0;
                        fa_next    = 1'b0;
                        fb_next    = 1'b0;
                        state_next = S_MG_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_PR_A;
                end
            end

            // Merge the two lightest active nodes.
            S_MG_RD:
            begin
                node_ra    = i_idx;
                state_next = S_MG_CMP;
            end
            S_MG_CMP:
            begin
                if (act_reg[i_idx])
                begin
                    if (!fa_reg || (nw_rd_reg < wa_reg))
                    begin
                        b_next  = a_reg;
                        wb_next = wa_reg;
                        fb_next = fa_reg;
                        a_next  = i_idx;
                        wa_next = nw_rd_reg;
                        fa_next = 1'b1;
                    end
                    else if (!fb_reg || (nw_rd_reg < wb_reg))
                    begin
                        b_next  = i_idx;
                        wb_next = nw_rd_reg;
                        fb_next = 1'b1;
                    end
                end
                if (i_reg == nx_reg - CNT_W'(1))
                begin
                    state_next = S_MG_WR;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_MG_RD;
                end
            end
            S_MG_WR:
            begin
                node_we = 1'b1;
                node_wa = nx_reg[IDX_W-1:0];
                nl_wd   = a_reg;
                nr_wd   = b_reg;
                np_wd   = 1'b0;
                nw_wd   = wa_reg + wb_reg;
                act_next[a_reg] = 1'b0;
                act_next[b_reg] = 1'b0;
                act_next[nx_reg[IDX_W-1:0]] = 1'b1;
                nx_next = nx_reg + CNT_W'(1);
                if (nx_reg == root_reg)
                begin
                    state_next = S_TH_INIT;
                end
                else
                begin
                    i_next     = '0;
                    fa_next    = 1'b0;
                    fb_next    = 1'b0;
                    state_next = S_MG_RD;
                end
            end

            // Top-down thresholds: acc carries the weight to the left of a node.
            S_TH_INIT:
            begin
                acc_we     = 1'b1;
                acc_wa     = root_reg[IDX_W-1:0];
                acc_wd     = '0;
                i_next     = root_reg;
                state_next = S_TH_RD;
            end
            S_TH_RD:
            begin
                node_ra    = i_idx;
                state_next = S_TH_C;
            end
            S_TH_C:
            begin
                if (np_rd_reg)
                begin
                    thr_we = 1'b1;
                    thr_wa = i_idx;
                    thr_wd = thr_rd_reg + acc_rd_reg;
                    if (i_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg - CNT_W'(1);
                        state_next = S_TH_RD;
                    end
                end
                else
                begin
                    a_next     = nl_rd_reg;
                    b_next     = nr_rd_reg;
                    wa_next    = acc_rd_reg;
                    node_ra    = nr_rd_reg;
                    state_next = S_TH_W1;
                end
            end
            S_TH_W1:
            begin
                thr_we     = 1'b1;
                thr_wa     = i_idx;
                thr_wd     = nw_rd_reg + wa_reg;
                acc_we     = 1'b1;
                acc_wa     = a_reg;
                acc_wd     = wa_reg + nw_rd_reg;
                state_next = S_TH_W2;
            end
            S_TH_W2:
            begin
                acc_we = 1'b1;
                acc_wa = b_reg;
                acc_wd = wa_reg;
                if (i_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg - CNT_W'(1);
                    state_next = S_TH_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ready_next      = 1'b1;
                    out_valid_next  = 1'b1;
                    out_next.status = ST_BUILT;
                    out_next.index  = '0;
                    out_next.total  = TOTAL_W'(sum_reg);
                    state_next      = S_IDLE;
                end
            end

            // Query: scale the draw by the total, then walk from the root.
            S_Q_M1:
            begin
                plo_next   = PLO_W'(u_reg) * PLO_W'(sum_reg[FIELD_W-1:0]);
                phi_next   = PHI_W'(u_reg) * PHI_W'(sum_reg[SUM_W-1:FIELD_W]);
                state_next = S_Q_M2;
            end
            S_Q_M2:
            begin
                x_next     = SUM_W'(phi_reg) + SUM_W'(plo_reg[PLO_W-1:FIELD_W]);
                node_ra    = root_reg[IDX_W-1:0];
                a_next     = root_reg[IDX_W-1:0];
                state_next = S_Q_WALK;
            end
            S_Q_WALK:
            begin
                if (np_rd_reg)
                begin
                    node_ra = a_reg;
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_next.status = ST_SAMPLE;
                        out_next.index  = INDEX_W'(sel);
                        out_next.total  = TOTAL_W'(sum_reg);
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    node_ra = sel;
                    a_next  = sel;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            ready_reg     <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            lv_reg        <= '0;
            root_reg      <= '0;
            nx_reg        <= '0;
            fa_reg        <= 1'b0;
            fb_reg        <= 1'b0;
            act_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            ready_reg     <= ready_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rank_reg      <= rank_next;
            lv_reg        <= lv_next;
            root_reg      <= root_next;
            nx_reg        <= nx_next;
            fa_reg        <= fa_next;
            fb_reg        <= fb_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        wa_reg  <= wa_next;
        wb_reg  <= wb_next;
        ra_reg  <= ra_next;
        ri_reg  <= ri_next;
        u_reg   <= u_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        x_reg   <= x_next;
        out_reg <= out_next;
    end

    // A walk only runs over a finished tree.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_WALK) |-> ready_reg)
        else $error("walk without a built tree");

    // A merge always joins two distinct active nodes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MG_WR) |-> (fa_reg && fb_reg && (a_reg != b_reg)))
        else $error("merge without two distinct nodes");

    // Finishing a build marks the tree ready and posts the reply.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> (ready_reg && out_valid_reg))
        else $error("build finished without reply");

endmodule

>>> hdl/huffman_tree_weighted_sampler.sv
// Load word: only the last load of a set, or a load into a full event memory, posts a word.
// Build (n events, L = ceil(n/2)): a stable rank sort, pairing into L leaves,
// merge scans over the active nodes and a top-down threshold pass, one memory read a step.
// Query: scale the draw by the total, then walk one tree level a step (1 to L levels).
// Reset clears the queue, the sequencer, counts, sum and tree flag; the
// event and node memories are not cleared and need no clearing pass.
module huffman_tree_weighted_sampler #(
    parameter int MAX_EVENTS = hts_pkg::MAX_EVENTS_DEF,
    parameter int RATE_BITS  = hts_pkg::RATE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [hts_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // event_rate, uniform_draw
    input  logic                             s_axis_tlast,   // last_event
    input  logic                             s_axis_tuser,   // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [hts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // event_index, total_rate, zero pad
    output logic [1:0]                       m_axis_tuser    // status
);
    import hts_pkg::*;

    logic        item_valid;
    logic        item_ready;
    hts_item_t   item;
    hts_result_t res;

    // Front end: accepts and classifies words.
    hts_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    // Back end: loads, builds the tree and walks it.
    hts_back #(
        .MAX_EVENTS (MAX_EVENTS),
        .RATE_BITS  (RATE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    // Pack the result word.
    assign m_axis_tdata = {{(OUT_DATA_W - INDEX_W - TOTAL_W){1'b0}}, res.total, res.index};
    assign m_axis_tuser = res.status;

endmodule
